### src/lrt_pkg.sv
// shared types, register codes and helpers for the thick line rasterizer
package lrt_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int MAX_THICK = 16;

  localparam int COORD_W = 11;
  localparam int IN_W    = 10;
  localparam int THICK_W = 5;
  localparam int ERR_W   = 13;
  localparam int INDEX_W = 21;
  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd4;

  localparam logic [COORD_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [COORD_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [7:0]         COLOR_RESET  = 8'd255;

  typedef struct packed {
    logic               pix;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
  } pix_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [IN_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (int'(v) >= MAX_DIM) begin
      r = COORD_W'(MAX_DIM - 1);
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

  function automatic logic [THICK_W-1:0] extra_passes(input logic [THICK_W-1:0] th);
    logic [THICK_W-1:0] r;
    if (th == '0) begin
      r = '0;
    end else if (int'(th) > MAX_THICK) begin
      r = THICK_W'(MAX_THICK - 1);
    end else begin
      r = th - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

endpackage

### src/line_rasterizer_thick.sv
// top level of the thick line rasterizer: line stepping, pixel index and color
// a transfer accepted into the s1 stage is registered again into the result register
// throughput: one item per cycle, held back only while the result register waits
// the stepping state and the result pipe stall together on result_ready
// reset: synchronous, clears the line state and the pipe, frame 640x480, color white
module line_rasterizer_thick
  import lrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic                  operation,
  input  logic [IN_W-1:0]       start_x,
  input  logic [IN_W-1:0]       start_y,
  input  logic [IN_W-1:0]       end_x,
  input  logic [IN_W-1:0]       end_y,
  input  logic [THICK_W-1:0]    line_thickness,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  pixel_valid,
  output logic [COORD_W-1:0]    pixel_x,
  output logic [COORD_W-1:0]    pixel_y,
  output logic [INDEX_W-1:0]    pixel_index,
  output logic                  on_screen,
  output logic [COLOR_W-1:0]    pixel_color,
  output logic                  last_pixel
);

  logic [COORD_W-1:0] image_width, image_height;
  logic [7:0]         draw_red, draw_green, draw_blue;

  logic                line_active, steep_flag, minor_dir_down;
  logic [COORD_W-1:0]  major_pos, major_end, minor_pos, delta_major, delta_minor;
  logic signed [ERR_W-1:0] error_term;
  logic [THICK_W-1:0]  passes_left;
  logic [COORD_W-1:0]  origin_major, origin_minor;

  logic                line_active_next, steep_flag_next, minor_dir_down_next;
  logic [COORD_W-1:0]  major_pos_next, major_end_next, minor_pos_next;
  logic [COORD_W-1:0]  delta_major_next, delta_minor_next;
  logic signed [ERR_W-1:0] error_term_next;
  logic [THICK_W-1:0]  passes_left_next;
  logic [COORD_W-1:0]  origin_major_next, origin_minor_next;

  logic s1_valid;
  pix_t s1, s1_next;

  logic advance_pipe, item_xfer;

  logic [COORD_W-1:0] x0, y0, x1, y1, dx, dy, a0, b0, a1, b1;
  logic               steep;
  logic signed [ERR_W-1:0] err_sum;
  logic [2*COORD_W-1:0] prod;
  logic [2*COORD_W-1:0] lin;

  assign cfg_ready    = 1'b1;
  assign advance_pipe = !result_valid || result_ready;
  assign item_ready   = advance_pipe;
  assign item_xfer    = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      draw_red     <= COLOR_RESET;
      draw_green   <= COLOR_RESET;
      draw_blue    <= COLOR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_RED:    draw_red     <= cfg_data[7:0];
        REG_GREEN:  draw_green   <= cfg_data[7:0];
        REG_BLUE:   draw_blue    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    x0 = clamp_coord(start_x);
    y0 = clamp_coord(start_y);
    x1 = clamp_coord(end_x);
    y1 = clamp_coord(end_y);
    dx = abs_diff(x0, x1);
    dy = abs_diff(y0, y1);
    steep = dy > dx;
    a0 = steep ? y0 : x0;
    b0 = steep ? x0 : y0;
    a1 = steep ? y1 : x1;
    b1 = steep ? x1 : y1;
    if (a1 < a0) begin
      a0 = steep ? y1 : x1;
      b0 = steep ? x1 : y1;
      a1 = steep ? y0 : x0;
      b1 = steep ? x0 : y0;
    end

    line_active_next    = line_active;
    steep_flag_next     = steep_flag;
    minor_dir_down_next = minor_dir_down;
    major_pos_next      = major_pos;
    major_end_next      = major_end;
    minor_pos_next      = minor_pos;
    delta_major_next    = delta_major;
    delta_minor_next    = delta_minor;
    error_term_next     = error_term;
    passes_left_next    = passes_left;
    origin_major_next   = origin_major;
    origin_minor_next   = origin_minor;

    // new line: load state before the first pixel
    if (operation == OP_START) begin
      line_active_next    = 1'b1;
      steep_flag_next     = steep;
      delta_major_next    = a1 - a0;
      delta_minor_next    = abs_diff(b0, b1);
      minor_dir_down_next = !(b0 < b1);
      origin_major_next   = a0;
      origin_minor_next   = b0;
      major_end_next      = a1;
      passes_left_next    = extra_passes(line_thickness);
      major_pos_next      = a0;
      minor_pos_next      = b0;
      error_term_next     = -$signed({2'b00, a1 - a0});
    end

    s1_next.pix  = line_active_next;
    s1_next.x    = '0;
    s1_next.y    = '0;
    s1_next.last = 1'b0;
    err_sum      = error_term_next + $signed({1'b0, delta_minor_next, 1'b0});

    if (line_active_next) begin
      s1_next.x    = steep_flag_next ? minor_pos_next : major_pos_next;
      s1_next.y    = steep_flag_next ? major_pos_next : minor_pos_next;
      s1_next.last = (major_pos_next == major_end_next) && (passes_left_next == '0);

      if (major_pos_next == major_end_next) begin
        if (passes_left_next != '0) begin
          passes_left_next  = passes_left_next - 1'b1;
          origin_major_next = origin_major_next + 1'b1;
          origin_minor_next = origin_minor_next + 1'b1;
          major_end_next    = major_end_next + 1'b1;
          major_pos_next    = origin_major_next;
          minor_pos_next    = origin_minor_next;
          error_term_next   = -$signed({2'b00, delta_major_next});
        end else begin
          line_active_next = 1'b0;
        end
      end else begin
        major_pos_next  = major_pos_next + 1'b1;
        error_term_next = err_sum;
        if (err_sum >= 0) begin
          minor_pos_next  = minor_dir_down_next ? minor_pos_next - 1'b1
                                                : minor_pos_next + 1'b1;
          error_term_next = err_sum - $signed({1'b0, delta_major_next, 1'b0});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active    <= 1'b0;
      steep_flag     <= 1'b0;
      minor_dir_down <= 1'b0;
      major_pos      <= '0;
      major_end      <= '0;
      minor_pos      <= '0;
      delta_major    <= '0;
      delta_minor    <= '0;
      error_term     <= '0;
      passes_left    <= '0;
      origin_major   <= '0;
      origin_minor   <= '0;
    end else if (item_xfer) begin
      line_active    <= line_active_next;
      steep_flag     <= steep_flag_next;
      minor_dir_down <= minor_dir_down_next;
      major_pos      <= major_pos_next;
      major_end      <= major_end_next;
      minor_pos      <= minor_pos_next;
      delta_major    <= delta_major_next;
      delta_minor    <= delta_minor_next;
      error_term     <= error_term_next;
      passes_left    <= passes_left_next;
      origin_major   <= origin_major_next;
      origin_minor   <= origin_minor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance_pipe) begin
      s1_valid     <= item_xfer;
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance_pipe && item_xfer) begin
      s1 <= s1_next;
    end
  end

  assign prod = {{COORD_W{1'b0}}, s1.y} * {{COORD_W{1'b0}}, image_width};
  assign lin  = prod + {{COORD_W{1'b0}}, s1.x};

  always_ff @(posedge clk) begin
    if (advance_pipe && s1_valid) begin
      pixel_valid <= s1.pix;
      pixel_x     <= s1.x;
      pixel_y     <= s1.y;
      pixel_index <= s1.pix ? lin[INDEX_W-1:0] : '0;
      on_screen   <= s1.pix && (s1.x < image_width) && (s1.y < image_height);
      pixel_color <= s1.pix ? {draw_red, draw_green, draw_blue} : '0;
      last_pixel  <= s1.last;
    end
  end

endmodule

### src/lrt_checker.sv
// port-level assertions for the thick line rasterizer, bound to the top level
module lrt_checker
  import lrt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input logic               pixel_valid,
  input logic [COORD_W-1:0] pixel_x,
  input logic [COORD_W-1:0] pixel_y,
  input logic [INDEX_W-1:0] pixel_index,
  input logic               on_screen,
  input logic [COLOR_W-1:0] pixel_color,
  input logic               last_pixel
);

  // stalled result stays up
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // no active line gives an all-zero result
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 &&
      pixel_index == '0 && pixel_color == '0 && !on_screen && !last_pixel)
    else $error("inactive result carries nonzero fields");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_pixel |-> pixel_valid)
    else $error("last flag without a pixel");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending right after reset");

  // an idle pipe is never blocked
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> item_ready)
    else $error("item refused with empty result register");

endmodule

bind line_rasterizer_thick lrt_checker u_lrt_checker (.*);

### dv/tb_line_rasterizer_thick.sv
`timescale 1ns / 1ps
// self-checking testbench for the thick line rasterizer: directed and random lines, pixel by pixel
module tb_line_rasterizer_thick;
  import lrt_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASES       = 7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {RX_FREE, RX_SPARSE, RX_COIN, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [INDEX_W-1:0] index;
    logic               on;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  item_valid     = 1'b0;
  logic                  item_ready;
  logic                  operation      = OP_START;
  logic [IN_W-1:0]       start_x        = '0;
  logic [IN_W-1:0]       start_y        = '0;
  logic [IN_W-1:0]       end_x          = '0;
  logic [IN_W-1:0]       end_y          = '0;
  logic [THICK_W-1:0]    line_thickness = '0;
  logic                  result_valid;
  logic                  result_ready   = 1'b0;
  logic                  pixel_valid;
  logic [COORD_W-1:0]    pixel_x;
  logic [COORD_W-1:0]    pixel_y;
  logic [INDEX_W-1:0]    pixel_index;
  logic                  on_screen;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  last_pixel;

  // predictor copy of registers and walk state
  logic [COORD_W-1:0] frame_w = WIDTH_RESET;
  logic [COORD_W-1:0] frame_h = HEIGHT_RESET;
  logic [7:0]         red     = COLOR_RESET;
  logic [7:0]         green   = COLOR_RESET;
  logic [7:0]         blue    = COLOR_RESET;
  logic               walk_active  = 1'b0;
  logic               walk_steep   = 1'b0;
  logic               walk_down    = 1'b0;
  logic [COORD_W-1:0] major_at     = '0;
  logic [COORD_W-1:0] major_stop   = '0;
  logic [COORD_W-1:0] minor_at     = '0;
  logic [COORD_W-1:0] span_major   = '0;
  logic [COORD_W-1:0] span_minor   = '0;
  logic [COORD_W-1:0] origin_major = '0;
  logic [COORD_W-1:0] origin_minor = '0;
  int                 err_acc      = 0;
  int                 passes_to_go = 0;

  pixel_t   pending_pixels[$];
  pixel_t   want_pixel;
  int       error_count   = 0;
  int       checked_count = 0;
  int       items_sent    = 0;
  int       lines_started = 0;
  int       cycle_count   = 0;
  int       burst_left    = 5;
  int       stall_left    = 0;
  rx_mode_t stall_mode    = RX_FREE;

  line_rasterizer_thick uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .operation      (operation),
    .start_x        (start_x),
    .start_y        (start_y),
    .end_x          (end_x),
    .end_y          (end_y),
    .line_thickness (line_thickness),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .pixel_valid    (pixel_valid),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_index    (pixel_index),
    .on_screen      (on_screen),
    .pixel_color    (pixel_color),
    .last_pixel     (last_pixel)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic [COORD_W-1:0] saturate_coord(input logic [IN_W-1:0] v);
    if (int'(v) >= MAX_DIM) begin
      return COORD_W'(MAX_DIM - 1);
    end
    return COORD_W'(v);
  endfunction

  function void restart_pass();
    major_at = origin_major;
    minor_at = origin_minor;
    err_acc  = -int'(span_major);
  endfunction

  task automatic predict_pixel(input logic op, input logic [IN_W-1:0] sx, sy, ex, ey,
                               input logic [THICK_W-1:0] th);
    logic [COORD_W-1:0] x0, y0, x1, y1, a0, b0, a1, b1, dx, dy, px, py;
    logic [31:0]        idx;
    int                 passes;
    pixel_t             p;
    p = '0;
    if (op == OP_START) begin
      x0 = saturate_coord(sx);
      y0 = saturate_coord(sy);
      x1 = saturate_coord(ex);
      y1 = saturate_coord(ey);
      dx = (x0 > x1) ? x0 - x1 : x1 - x0;
      dy = (y0 > y1) ? y0 - y1 : y1 - y0;
      passes = int'(th);
      if (passes == 0) passes = 1;
      if (passes > MAX_THICK) passes = MAX_THICK;
      walk_steep = dy > dx;
      if (walk_steep) begin
        a0 = y0; b0 = x0; a1 = y1; b1 = x1;
      end else begin
        a0 = x0; b0 = y0; a1 = x1; b1 = y1;
      end
      if (a1 < a0) begin
        {a0, a1} = {a1, a0};
        {b0, b1} = {b1, b0};
      end
      span_major   = a1 - a0;
      span_minor   = (b0 > b1) ? b0 - b1 : b1 - b0;
      walk_down    = !(b0 < b1);
      origin_major = a0;
      origin_minor = b0;
      major_stop   = a1;
      passes_to_go = passes - 1;
      restart_pass();
      walk_active = 1'b1;
      lines_started++;
    end
    if (walk_active) begin
      px = walk_steep ? minor_at : major_at;
      py = walk_steep ? major_at : minor_at;
      idx = 32'(py) * 32'(frame_w) + 32'(px);
      p.valid = 1'b1;
      p.x     = px;
      p.y     = py;
      p.index = idx[INDEX_W-1:0];
      p.on    = (px < frame_w) && (py < frame_h);
      p.color = {red, green, blue};
      p.last  = (major_at == major_stop) && (passes_to_go == 0);
      if (major_at == major_stop) begin
        if (passes_to_go > 0) begin
          passes_to_go--;
          origin_major = origin_major + 1'b1;
          origin_minor = origin_minor + 1'b1;
          major_stop   = major_stop + 1'b1;
          restart_pass();
        end else begin
          walk_active = 1'b0;
        end
      end else begin
        major_at = major_at + 1'b1;
        err_acc += 2 * int'(span_minor);
        if (err_acc >= 0) begin
          minor_at = walk_down ? minor_at - 1'b1 : minor_at + 1'b1;
          err_acc -= 2 * int'(span_major);
        end
      end
    end
    pending_pixels.insert(pending_pixels.size(), p);
  endtask

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input logic op, input logic [IN_W-1:0] sx, sy, ex, ey,
                           input logic [THICK_W-1:0] th);
    item_valid     <= 1'b1;
    operation      <= op;
    start_x        <= sx;
    start_y        <= sy;
    end_x          <= ex;
    end_y          <= ey;
    line_thickness <= th;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    predict_pixel(op, sx, sy, ex, ey, th);
    items_sent++;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task send_step();
    send_item(OP_STEP, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
              THICK_W'($urandom));
  endtask

  task wait_idle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WIDTH:  frame_w = data;
      REG_HEIGHT: frame_h = data;
      REG_RED:    red     = data[7:0];
      REG_GREEN:  green   = data[7:0];
      REG_BLUE:   blue    = data[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] w, h, r, g, b);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RED, r);
    write_reg(REG_GREEN, g);
    write_reg(REG_BLUE, b);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return '1;
      3:       return CFG_DATA_W'(MAX_DIM);
      4:       return WIDTH_RESET;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] near_coord(input logic [IN_W-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 24)) - 12;
    if (t < 0) t = 0;
    if (t > MAX_DIM - 1) t = MAX_DIM - 1;
    return IN_W'(t);
  endfunction

  task test_idle_and_reset_values();
    send_step();
    send_step();
    send_item(OP_START, 10'd0, 10'd0, 10'd0, 10'd0, 5'd1);
    send_step();
  endtask

  task test_line_shapes();
    // reversed shallow line with thickness zero
    send_item(OP_START, 10'd1023, 10'd1023, 10'd1020, 10'd1021, 5'd0);
    repeat (3) send_step();
    // steep line, minor axis moving down, two passes
    send_item(OP_START, 10'd2, 10'd0, 10'd1, 10'd3, 5'd2);
    repeat (8) send_step();
    // saturated thickness, dropped by a new start
    send_item(OP_START, 10'd1023, 10'd0, 10'd1023, 10'd1023, 5'd31);
    repeat (2) send_step();
    send_item(OP_START, 10'd0, 10'd5, 10'd3, 10'd5, 5'd1);
    repeat (4) send_step();
  endtask

  task test_frame_extremes();
    set_config('0, '0, '0, '0, '0);
    send_item(OP_START, 10'd7, 10'd3, 10'd7, 10'd3, 5'd1);
    // widest frame, passes beyond the largest input coordinate make the index wrap
    set_config('1, '1, 11'h7ff, 11'h700, 11'h0aa);
    write_reg(REG_SPARE, 11'h555);
    send_item(OP_START, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 5'd3);
    repeat (2) send_step();
    set_config(11'd1, 11'd1, 11'd255, 11'd0, 11'd255);
    send_item(OP_START, 10'd0, 10'd0, 10'd1, 10'd1, 5'd1);
    send_step();
  endtask

  task test_random_lines();
    int               target, kind, n;
    logic [IN_W-1:0]  bx, by;
    logic [THICK_W-1:0] th;
    for (int phase = 0; phase < PHASES; phase++) begin
      set_config(pick_dim(), pick_dim(), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                 CFG_DATA_W'($urandom));
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          bx = IN_W'($urandom);
          by = IN_W'($urandom);
          th = ($urandom_range(0, 3) == 0) ? THICK_W'($urandom) : THICK_W'($urandom_range(1, 3));
          send_item(OP_START, bx, by, near_coord(bx), near_coord(by), th);
          n = 0;
          while (walk_active && n < 80) begin
            send_step();
            n++;
          end
          if ($urandom_range(0, 2) == 0) send_step();
        end else if (kind < 9) begin
          // long line, cut short by the next start
          send_item(OP_START, IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                    IN_W'($urandom), THICK_W'($urandom));
          repeat ($urandom_range(3, 30)) send_step();
        end else begin
          repeat ($urandom_range(1, 5)) begin
            send_item(1'($urandom), IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
                      IN_W'($urandom), THICK_W'($urandom));
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(pixel_x), 0);
      end else begin
        want_pixel = pending_pixels.pop_front();
        checked_count++;
        if (pixel_valid !== want_pixel.valid)
          report_mismatch("pixel_valid", 32'(pixel_valid), 32'(want_pixel.valid));
        if (pixel_x !== want_pixel.x)
          report_mismatch("pixel_x", 32'(pixel_x), 32'(want_pixel.x));
        if (pixel_y !== want_pixel.y)
          report_mismatch("pixel_y", 32'(pixel_y), 32'(want_pixel.y));
        if (pixel_index !== want_pixel.index)
          report_mismatch("pixel_index", 32'(pixel_index), 32'(want_pixel.index));
        if (on_screen !== want_pixel.on)
          report_mismatch("on_screen", 32'(on_screen), 32'(want_pixel.on));
        if (pixel_color !== want_pixel.color)
          report_mismatch("pixel_color", 32'(pixel_color), 32'(want_pixel.color));
        if (last_pixel !== want_pixel.last)
          report_mismatch("last_pixel", 32'(last_pixel), 32'(want_pixel.last));
      end
    end
    if (stall_left == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_FREE:   result_ready <= 1'b1;
      RX_SPARSE: result_ready <= ($urandom_range(0, 3) != 0);
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      default:   result_ready <= ((cycle_count % 5) >= 2);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_and_reset_values();
    test_line_shapes();
    test_frame_extremes();
    test_random_lines();
    item_valid <= 1'b0;
    n = 0;
    @(posedge clk);
    while (pending_pixels.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch("pixels never delivered", pending_pixels.size(), 0);
    $display("ran %0d items over %0d lines, compared %0d pixels", items_sent, lines_started,
             checked_count);
    $display("frame sizes from zero to full range, thickness zero to saturated, %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
src/lrt_pkg.sv
src/line_rasterizer_thick.sv
src/lrt_checker.sv
dv/tb_line_rasterizer_thick.sv
